/* src/wheel_drive_mixer_unit_assert.svh */
// ---------------------------------------------------------------------------
// Wheel drive mixer assertion macros
// Shared property shorthands for the checker of the wheel drive mixer.
// ---------------------------------------------------------------------------
`ifndef WHEEL_DRIVE_MIXER_UNIT_ASSERT_SVH
`define WHEEL_DRIVE_MIXER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define WDM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, sampled on the rising edge, off while in reset.
`define WDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* src/wdm_pkg.sv */
// ---------------------------------------------------------------------------
// Wheel drive mixer package
// Widths, register codes, reset values and pipeline payload types.
// ---------------------------------------------------------------------------
package wdm_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 21;
  localparam int MODE_W     = 3;
  localparam int COUNT_W    = 3;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 8;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int NUM_WHEELS = 4;

  // A signed sum of three rates needs two more bits; its magnitude one more.
  localparam int SUM_W  = IN_W + 2;
  localparam int MAG_W  = IN_W + 1;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int DIV_W  = (MAG_W > QUO_W) ? MAG_W : QUO_W;
  localparam int REM_W  = DIV_W + 1;
  localparam int PROD_W = QUO_W + GAIN_W;
  localparam int PSH_W  = PROD_W - GAIN_FRAC;
  localparam int EXT_W  = ((PSH_W > OUT_W) ? PSH_W : OUT_W) + 1;

  localparam int FRONT_STAGES = 4;
  localparam int GAIN_STAGES  = 2;
  localparam int NUM_STAGES   = FRONT_STAGES + QUO_W + GAIN_STAGES;

  localparam logic [DIV_W-1:0] ONE_FX = {{(DIV_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  localparam logic signed [EXT_W-1:0] WHEEL_MAX = EXT_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] WHEEL_MIN = -EXT_W'(2 ** (OUT_W - 1));

  localparam logic [COUNT_W-1:0] WHEELS_FOUR = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] WHEELS_TWO  = COUNT_W'(2);

  localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_W'(0);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4);
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(256);

  typedef enum logic [MODE_W-1:0] {
    MODE_MECANUM     = 3'd0,
    MODE_PARALLEL4   = 3'd1,
    MODE_PARALLEL2   = 3'd2,
    MODE_OMNI_CROSS  = 3'd3,
    MODE_OMNI_PLUS   = 3'd4
  } mix_mode_e;

  typedef enum logic [ADDR_W-3:0] {
    REG_MIX_MODE    = 2'd0,
    REG_WHEEL_COUNT = 2'd1,
    REG_OUTPUT_GAIN = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mix_mode;
    logic [COUNT_W-1:0] wheel_count;
    logic [GAIN_W-1:0]  output_gain;
  } cfg_t;

  typedef struct packed {
    logic                                err;
    logic [NUM_WHEELS-1:0]               neg;
    logic [DIV_W-1:0]                    dvs;
    logic [NUM_WHEELS-1:0][REM_W-1:0]    rem;
    logic [NUM_WHEELS-1:0][QUO_W-1:0]    quo;
  } div_t;

endpackage

/* src/wheel_drive_mixer_unit.sv */
// ---------------------------------------------------------------------------
// Wheel drive mixer
// Turns a motion vector into four wheel commands with desaturation and gain.
// ---------------------------------------------------------------------------
// A request enters through a valid/ready handshake and passes through
// 4 + FRAC_BITS + 1 + 2 stages on the way to its result, with one request
// accepted in every cycle while the output side keeps taking results; a
// stall at the output fills empty stages first, so input ready only drops
// once every stage holds a request. Most of the stages form the restoring
// divider that scales all four wheels when the largest magnitude exceeds
// 1.0: it settles one quotient bit per stage. Registers sit on an APB-style
// port: mix_mode at 0x0, wheel_count at 0x4 and output_gain at 0x8. Change
// them only while no request is in flight; they take effect for requests
// accepted afterwards.
module wheel_drive_mixer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [wdm_pkg::IN_W-1:0]    forward_rate_i,
  input  logic signed [wdm_pkg::IN_W-1:0]    side_rate_i,
  input  logic signed [wdm_pkg::IN_W-1:0]    turn_rate_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [wdm_pkg::OUT_W-1:0]   wheel_a_o,
  output logic signed [wdm_pkg::OUT_W-1:0]   wheel_b_o,
  output logic signed [wdm_pkg::OUT_W-1:0]   wheel_c_o,
  output logic signed [wdm_pkg::OUT_W-1:0]   wheel_d_o,
  output logic                               mix_error_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wdm_pkg::ADDR_W-1:0]         paddr,
  input  logic [wdm_pkg::DATA_W-1:0]         pwdata,
  output logic [wdm_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam int NS = wdm_pkg::NUM_STAGES;
  localparam int FS = wdm_pkg::FRONT_STAGES;

  wdm_pkg::cfg_t                    cfg;
  logic [NS-1:0]                    vld_q;
  logic [NS-1:0]                    vld_d;
  logic [NS-1:0]                    vld_shift;
  logic [NS-1:0]                    rdy;
  wdm_pkg::div_t                    div_data [wdm_pkg::QUO_W+1];
  logic signed [wdm_pkg::OUT_W-1:0] wheel [wdm_pkg::NUM_WHEELS];

  assign pready = 1'b1;

  wdm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // A stage may load when the output is taken or some stage at or after it
  // is empty, so bubbles close up during a stall.
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = out_ready_i | ~(&vld_q[NS-1:k]);
  end

  assign vld_shift = {vld_q[NS-2:0], in_valid_i};
  assign vld_d     = (rdy & vld_shift) | (~rdy & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];

  wdm_front u_front (
    .clk_i          (clk_i),
    .en_i           (rdy[FS-1:0]),
    .cfg_i          (cfg),
    .forward_rate_i (forward_rate_i),
    .side_rate_i    (side_rate_i),
    .turn_rate_i    (turn_rate_i),
    .data_o         (div_data[0])
  );

  for (genvar j = 0; j < wdm_pkg::QUO_W; j++) begin : g_div
    wdm_div_stage u_div_stage (
      .clk_i  (clk_i),
      .en_i   (rdy[FS+j]),
      .data_i (div_data[j]),
      .data_o (div_data[j+1])
    );
  end

  wdm_gain u_gain (
    .clk_i   (clk_i),
    .en_i    (rdy[NS-1:NS-wdm_pkg::GAIN_STAGES]),
    .gain_i  (cfg.output_gain),
    .data_i  (div_data[wdm_pkg::QUO_W]),
    .wheel_o (wheel),
    .err_o   (mix_error_o)
  );

  assign wheel_a_o = wheel[0];
  assign wheel_b_o = wheel[1];
  assign wheel_c_o = wheel[2];
  assign wheel_d_o = wheel[3];

endmodule

/* src/wdm_regs.sv */
// ---------------------------------------------------------------------------
// Wheel drive mixer configuration registers
// APB-style register file holding mode, wheel count and output gain.
// ---------------------------------------------------------------------------
module wdm_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wdm_pkg::ADDR_W-1:0]  paddr,
  input  logic [wdm_pkg::DATA_W-1:0]  pwdata,
  output logic [wdm_pkg::DATA_W-1:0]  prdata,
  output wdm_pkg::cfg_t               cfg_o
);

  wdm_pkg::cfg_t     cfg_q;
  wdm_pkg::cfg_t     cfg_d;
  wdm_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx   = wdm_pkg::reg_idx_e'(paddr[wdm_pkg::ADDR_W-1:2]);
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    cfg_d  = cfg_q;
    prdata = '0;
    case (idx)
      wdm_pkg::REG_MIX_MODE: begin
        prdata = wdm_pkg::DATA_W'(cfg_q.mix_mode);
        if (wr_en) cfg_d.mix_mode = pwdata[wdm_pkg::MODE_W-1:0];
      end
      wdm_pkg::REG_WHEEL_COUNT: begin
        prdata = wdm_pkg::DATA_W'(cfg_q.wheel_count);
        if (wr_en) cfg_d.wheel_count = pwdata[wdm_pkg::COUNT_W-1:0];
      end
      wdm_pkg::REG_OUTPUT_GAIN: begin
        prdata = wdm_pkg::DATA_W'(cfg_q.output_gain);
        if (wr_en) cfg_d.output_gain = pwdata[wdm_pkg::GAIN_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mix_mode    <= wdm_pkg::MODE_RESET;
      cfg_q.wheel_count <= wdm_pkg::COUNT_RESET;
      cfg_q.output_gain <= wdm_pkg::GAIN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/wdm_front.sv */
// ---------------------------------------------------------------------------
// Wheel drive mixer front end
// Mixes the rates into wheel values, takes magnitudes, finds the largest
// and chooses the divisor for normalisation. Four register stages.
// ---------------------------------------------------------------------------
module wdm_front (
  input  logic                                  clk_i,
  input  logic [wdm_pkg::FRONT_STAGES-1:0]      en_i,
  input  wdm_pkg::cfg_t                         cfg_i,
  input  logic signed [wdm_pkg::IN_W-1:0]       forward_rate_i,
  input  logic signed [wdm_pkg::IN_W-1:0]       side_rate_i,
  input  logic signed [wdm_pkg::IN_W-1:0]       turn_rate_i,
  output wdm_pkg::div_t                         data_o
);

  localparam int NW = wdm_pkg::NUM_WHEELS;

  logic signed [wdm_pkg::SUM_W-1:0] f, s, t;
  logic signed [wdm_pkg::SUM_W-1:0] w_d [NW];
  logic                             err_d;

  // Stage 1: mixed wheel values.
  logic signed [wdm_pkg::SUM_W-1:0] w1_q [NW];
  logic                             err1_q;
  // Stage 2: sign and magnitude.
  logic [wdm_pkg::MAG_W-1:0]        mag2_q [NW];
  logic [NW-1:0]                    neg2_q;
  logic                             err2_q;
  // Stage 3: pairwise maxima.
  logic [wdm_pkg::MAG_W-1:0]        mag3_q [NW];
  logic [NW-1:0]                    neg3_q;
  logic                             err3_q;
  logic [wdm_pkg::MAG_W-1:0]        max01_q, max23_q;
  // Stage 4: divisor chosen.
  wdm_pkg::div_t                    data_q;
  logic [wdm_pkg::MAG_W-1:0]        max_all;
  logic [wdm_pkg::DIV_W-1:0]        max_ext;

  assign f = wdm_pkg::SUM_W'(forward_rate_i);
  assign s = wdm_pkg::SUM_W'(side_rate_i);
  assign t = wdm_pkg::SUM_W'(turn_rate_i);

  // A rejected mode or wheel count sends zeros down the pipe, which the
  // divider and gain stages keep at zero.
  always_comb begin
    err_d = 1'b1;
    for (int i = 0; i < NW; i++) w_d[i] = '0;
    case (wdm_pkg::mix_mode_e'(cfg_i.mix_mode))
      wdm_pkg::MODE_MECANUM: begin
        if (cfg_i.wheel_count == wdm_pkg::WHEELS_FOUR) begin
          err_d  = 1'b0;
          w_d[0] = f - s + t;
          w_d[1] = f + s + t;
          w_d[2] = -f + s + t;
          w_d[3] = -f - s + t;
        end
      end
      wdm_pkg::MODE_PARALLEL4: begin
        if (cfg_i.wheel_count == wdm_pkg::WHEELS_FOUR) begin
          err_d  = 1'b0;
          w_d[0] = -f;
          w_d[1] = f;
          w_d[2] = f;
          w_d[3] = -f;
        end
      end
      wdm_pkg::MODE_PARALLEL2: begin
        if (cfg_i.wheel_count == wdm_pkg::WHEELS_TWO) begin
          err_d  = 1'b0;
          w_d[0] = -f;
          w_d[1] = f;
        end
      end
      wdm_pkg::MODE_OMNI_CROSS, wdm_pkg::MODE_OMNI_PLUS: begin
        err_d = 1'b1;
      end
      default: begin
        err_d = 1'b1;
      end
    endcase
  end

  assign max_all = (max01_q > max23_q) ? max01_q : max23_q;
  assign max_ext = wdm_pkg::DIV_W'(max_all);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      w1_q   <= w_d;
      err1_q <= err_d;
    end
    if (en_i[1]) begin
      for (int i = 0; i < NW; i++) begin
        neg2_q[i] <= w1_q[i][wdm_pkg::SUM_W-1];
        mag2_q[i] <= wdm_pkg::MAG_W'(w1_q[i][wdm_pkg::SUM_W-1] ? -w1_q[i] : w1_q[i]);
      end
      err2_q <= err1_q;
    end
    if (en_i[2]) begin
      mag3_q  <= mag2_q;
      neg3_q  <= neg2_q;
      err3_q  <= err2_q;
      max01_q <= (mag2_q[0] > mag2_q[1]) ? mag2_q[0] : mag2_q[1];
      max23_q <= (mag2_q[2] > mag2_q[3]) ? mag2_q[2] : mag2_q[3];
    end
    if (en_i[3]) begin
      // Dividing by one in fixed point leaves wheels that need no scaling as they are.
      data_q.dvs <= (max_ext > wdm_pkg::ONE_FX) ? max_ext : wdm_pkg::ONE_FX;
      data_q.err <= err3_q;
      data_q.neg <= neg3_q;
      data_q.quo <= '0;
      for (int i = 0; i < NW; i++) begin
        data_q.rem[i] <= wdm_pkg::REM_W'(mag3_q[i]);
      end
    end
  end

  assign data_o = data_q;

endmodule

/* src/wdm_div_stage.sv */
// ---------------------------------------------------------------------------
// Wheel drive mixer divider stage
// One restoring-division step for all four wheels: settles one quotient bit
// per lane and registers the partial remainder for the next stage.
// ---------------------------------------------------------------------------
module wdm_div_stage (
  input  logic          clk_i,
  input  logic          en_i,
  input  wdm_pkg::div_t data_i,
  output wdm_pkg::div_t data_o
);

  localparam int NW = wdm_pkg::NUM_WHEELS;

  wdm_pkg::div_t             data_d;
  wdm_pkg::div_t             data_q;
  logic [wdm_pkg::REM_W-1:0] dvs_ext;
  logic [wdm_pkg::REM_W-1:0] rem_sub [NW];
  logic [NW-1:0]             take;

  assign dvs_ext = wdm_pkg::REM_W'(data_i.dvs);

  // The remainder stays below the divisor after the subtract, so the shift
  // for the next bit always fits.
  always_comb begin
    data_d = data_i;
    for (int i = 0; i < NW; i++) begin
      take[i]       = data_i.rem[i] >= dvs_ext;
      rem_sub[i]    = take[i] ? (data_i.rem[i] - dvs_ext) : data_i.rem[i];
      data_d.rem[i] = {rem_sub[i][wdm_pkg::REM_W-2:0], 1'b0};
      data_d.quo[i] = {data_i.quo[i][wdm_pkg::QUO_W-2:0], take[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

/* src/wdm_gain.sv */
// ---------------------------------------------------------------------------
// Wheel drive mixer gain stage
// Multiplies each normalised magnitude by the Q8.8 gain, then restores the
// sign and clamps to the output range. Two register stages.
// ---------------------------------------------------------------------------
module wdm_gain (
  input  logic                                clk_i,
  input  logic [wdm_pkg::GAIN_STAGES-1:0]     en_i,
  input  logic [wdm_pkg::GAIN_W-1:0]          gain_i,
  input  wdm_pkg::div_t                       data_i,
  output logic signed [wdm_pkg::OUT_W-1:0]    wheel_o [wdm_pkg::NUM_WHEELS],
  output logic                                err_o
);

  localparam int NW = wdm_pkg::NUM_WHEELS;

  logic [wdm_pkg::PROD_W-1:0]       prod_q [NW];
  logic [NW-1:0]                    neg_q;
  logic                             err_q;
  logic [wdm_pkg::EXT_W-1:0]        mag_ext [NW];
  logic signed [wdm_pkg::EXT_W-1:0] val [NW];
  logic signed [wdm_pkg::OUT_W-1:0] wheel_d [NW];
  logic signed [wdm_pkg::OUT_W-1:0] wheel_q [NW];
  logic                             err_out_q;

  // Truncation toward zero: scale the magnitude, then apply the sign.
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      mag_ext[i] = wdm_pkg::EXT_W'(prod_q[i][wdm_pkg::PROD_W-1:wdm_pkg::GAIN_FRAC]);
      val[i]     = neg_q[i] ? -$signed(mag_ext[i]) : $signed(mag_ext[i]);
      if (val[i] > wdm_pkg::WHEEL_MAX) begin
        wheel_d[i] = wdm_pkg::WHEEL_MAX[wdm_pkg::OUT_W-1:0];
      end else if (val[i] < wdm_pkg::WHEEL_MIN) begin
        wheel_d[i] = wdm_pkg::WHEEL_MIN[wdm_pkg::OUT_W-1:0];
      end else begin
        wheel_d[i] = val[i][wdm_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < NW; i++) begin
        prod_q[i] <= wdm_pkg::PROD_W'(data_i.quo[i]) * wdm_pkg::PROD_W'(gain_i);
      end
      neg_q <= data_i.neg;
      err_q <= data_i.err;
    end
    if (en_i[1]) begin
      wheel_q   <= wheel_d;
      err_out_q <= err_q;
    end
  end

  assign wheel_o = wheel_q;
  assign err_o   = err_out_q;

endmodule

/* src/wdm_checker.sv */
// ---------------------------------------------------------------------------
// Wheel drive mixer checker
// Port-level assertions for the wheel drive mixer, bound to the top level.
// ---------------------------------------------------------------------------
`include "wheel_drive_mixer_unit_assert.svh"

module wdm_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_ready_o,
  input  logic                               out_valid_o,
  input  logic                               out_ready_i,
  input  logic signed [wdm_pkg::OUT_W-1:0]   wheel_a_o,
  input  logic signed [wdm_pkg::OUT_W-1:0]   wheel_b_o,
  input  logic signed [wdm_pkg::OUT_W-1:0]   wheel_c_o,
  input  logic signed [wdm_pkg::OUT_W-1:0]   wheel_d_o,
  input  logic                               mix_error_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wdm_pkg::ADDR_W-1:0]         paddr,
  input  logic [wdm_pkg::DATA_W-1:0]         pwdata,
  input  logic [wdm_pkg::DATA_W-1:0]         prdata,
  input  logic                               pready
);

  logic wr_mode;
  logic rd_mode;
  logic all_zero;

  assign wr_mode  = psel && penable && pwrite && pready &&
                    (paddr[wdm_pkg::ADDR_W-1:2] == wdm_pkg::REG_MIX_MODE);
  assign rd_mode  = psel && !pwrite &&
                    (paddr[wdm_pkg::ADDR_W-1:2] == wdm_pkg::REG_MIX_MODE);
  assign all_zero = (wheel_a_o == '0) && (wheel_b_o == '0) &&
                    (wheel_c_o == '0) && (wheel_d_o == '0);

  // A rejected mode or wheel count must never leak a wheel value.
  `WDM_ASSERT_IMPLIES(a_err_zero, clk_i, rst_ni, out_valid_o && mix_error_o, all_zero)

  // Taking results at the output always frees the input side.
  `WDM_ASSERT_IMPLIES(a_ready_follows, clk_i, rst_ni, out_ready_i, in_ready_o)

  // A waiting result holds its values.
  `WDM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(wheel_a_o) && $stable(wheel_b_o) && $stable(wheel_c_o) && $stable(wheel_d_o) && $stable(mix_error_o))

  // The mode register reads back what was just written to it.
  `WDM_ASSERT_IMPLIES(a_mode_readback, clk_i, rst_ni, wr_mode ##1 rd_mode, prdata[wdm_pkg::MODE_W-1:0] == $past(pwdata[wdm_pkg::MODE_W-1:0]))

endmodule

bind wheel_drive_mixer_unit wdm_checker u_wdm_checker (.*);

/* bench/tb_wheel_drive_mixer_unit.sv */
// ---------------------------------------------------------------------------
// Wheel drive mixer testbench
// Drives motion vectors through the valid/ready port with random gaps on
// both sides, sets mode, wheel count and gain over the APB port between
// phases, and compares every wheel set with an in-bench prediction.
// ---------------------------------------------------------------------------
module tb_wheel_drive_mixer_unit;
  import wdm_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic signed [OUT_W-1:0] wheel_a;
    logic signed [OUT_W-1:0] wheel_b;
    logic signed [OUT_W-1:0] wheel_c;
    logic signed [OUT_W-1:0] wheel_d;
    logic                    mix_error;
  } wheel_set_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [IN_W-1:0]  forward_rate_i;
  logic signed [IN_W-1:0]  side_rate_i;
  logic signed [IN_W-1:0]  turn_rate_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [OUT_W-1:0] wheel_a_o;
  logic signed [OUT_W-1:0] wheel_b_o;
  logic signed [OUT_W-1:0] wheel_c_o;
  logic signed [OUT_W-1:0] wheel_d_o;
  logic                    mix_error_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  // Shadow copy of the registers, kept in step with every write.
  logic [MODE_W-1:0]  cfg_mode  = MODE_RESET;
  logic [COUNT_W-1:0] cfg_count = COUNT_RESET;
  logic [GAIN_W-1:0]  cfg_gain  = GAIN_RESET;

  wheel_set_t wheel_expect_q[$];
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  bit         tx_idle_on = 1'b1;
  bit         rx_idle_on = 1'b1;

  wheel_drive_mixer_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .forward_rate_i (forward_rate_i),
    .side_rate_i    (side_rate_i),
    .turn_rate_i    (turn_rate_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .wheel_a_o      (wheel_a_o),
    .wheel_b_o      (wheel_b_o),
    .wheel_c_o      (wheel_c_o),
    .wheel_d_o      (wheel_d_o),
    .mix_error_o    (mix_error_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 93) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [IN_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return IN_W'($urandom());
      // Small enough that no mecanum sum reaches 1.0, so the gain sees raw values.
      5, 6, 7: return IN_W'($signed($urandom_range(0, 2730)) - 1365);
      8: begin
        case ($urandom_range(0, 6))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          3: return 16'shFFFF;
          4: return 16'sh0001;
          5: return 16'sh1000;
          default: return 16'shF000;
        endcase
      end
      default: return IN_W'($signed($urandom_range(0, 16)) + 4088);
    endcase
  endfunction

  function automatic wheel_set_t mix_wheels(input logic signed [IN_W-1:0] fwd,
                                            input logic signed [IN_W-1:0] side,
                                            input logic signed [IN_W-1:0] turn);
    longint     f, s, t, unit, peak, scaled;
    longint     w[NUM_WHEELS];
    bit         bad;
    wheel_set_t res;
    f = fwd;
    s = side;
    t = turn;
    unit = longint'(1) << FRAC_BITS;
    peak = 0;
    bad = 1'b0;
    foreach (w[i]) w[i] = 0;
    if (cfg_mode == MODE_MECANUM && cfg_count == WHEELS_FOUR) begin
      w[0] = f - s + t;
      w[1] = f + s + t;
      w[2] = -f + s + t;
      w[3] = -f - s + t;
    end else if (cfg_mode == MODE_PARALLEL4 && cfg_count == WHEELS_FOUR) begin
      w[0] = -f;
      w[1] = f;
      w[2] = f;
      w[3] = -f;
    end else if (cfg_mode == MODE_PARALLEL2 && cfg_count == WHEELS_TWO) begin
      w[0] = -f;
      w[1] = f;
    end else begin
      bad = 1'b1;
    end
    if (!bad) begin
      foreach (w[i]) begin
        if ((w[i] < 0 ? -w[i] : w[i]) > peak) peak = w[i] < 0 ? -w[i] : w[i];
      end
      // Desaturate: scale every wheel so that the largest lands on 1.0.
      if (peak > unit) begin
        foreach (w[i]) w[i] = w[i] * unit / peak;
      end
      foreach (w[i]) begin
        scaled = ((w[i] < 0 ? -w[i] : w[i]) * longint'(cfg_gain)) / 256;
        w[i] = w[i] < 0 ? -scaled : scaled;
        if (w[i] > WHEEL_MAX) w[i] = WHEEL_MAX;
        if (w[i] < WHEEL_MIN) w[i] = WHEEL_MIN;
      end
    end
    res.wheel_a   = OUT_W'(w[0]);
    res.wheel_b   = OUT_W'(w[1]);
    res.wheel_c   = OUT_W'(w[2]);
    res.wheel_d   = OUT_W'(w[3]);
    res.mix_error = bad;
    return res;
  endfunction

  task automatic check_wheel(input string label, input longint want, input longint got);
    if (want != got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  // Records each accepted request and checks each delivered wheel set.
  always @(posedge clk_i) begin : scoreboard
    wheel_set_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        wheel_expect_q.push_back(mix_wheels(forward_rate_i, side_rate_i, turn_rate_i));
      if (out_valid_o && out_ready_i) begin
        if (wheel_expect_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: wheel set with no request pending, expected none, actual %0d %0d %0d %0d %0d",
                   $time, wheel_a_o, wheel_b_o, wheel_c_o, wheel_d_o, mix_error_o);
        end else begin
          want = wheel_expect_q.pop_front();
          check_wheel("wheel_a", want.wheel_a, wheel_a_o);
          check_wheel("wheel_b", want.wheel_b, wheel_b_o);
          check_wheel("wheel_c", want.wheel_c, wheel_c_o);
          check_wheel("wheel_d", want.wheel_d, wheel_d_o);
          check_wheel("mix_error", want.mix_error, mix_error_o);
        end
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_cmd(input logic signed [IN_W-1:0] fwd,
                          input logic signed [IN_W-1:0] side,
                          input logic signed [IN_W-1:0] turn);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    forward_rate_i <= fwd;
    side_rate_i    <= side;
    turn_rate_i    <= turn;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Every request yields a result, so an empty queue means nothing is in flight.
  // The first edge lets the scoreboard record a request accepted just before.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (wheel_expect_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic read_reg(input reg_idx_e idx, output logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input reg_idx_e idx);
    logic [DATA_W-1:0] rd;
    read_reg(idx, rd);
    case (idx)
      REG_MIX_MODE:    check_wheel("mix_mode readback", cfg_mode, rd[MODE_W-1:0]);
      REG_WHEEL_COUNT: check_wheel("wheel_count readback", cfg_count, rd[COUNT_W-1:0]);
      default:         check_wheel("output_gain readback", cfg_gain, rd[GAIN_W-1:0]);
    endcase
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_MIX_MODE:    cfg_mode  = value[MODE_W-1:0];
      REG_WHEEL_COUNT: cfg_count = value[COUNT_W-1:0];
      default:         cfg_gain  = value[GAIN_W-1:0];
    endcase
    check_reg(idx);
  endtask

  task automatic set_mix(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count,
                         input logic [GAIN_W-1:0] gain);
    wait_idle();
    write_reg(REG_MIX_MODE, DATA_W'(mode));
    write_reg(REG_WHEEL_COUNT, DATA_W'(count));
    write_reg(REG_OUTPUT_GAIN, DATA_W'(gain));
  endtask

  task automatic run_random(input int n);
    repeat (n) send_cmd(pick_rate(), pick_rate(), pick_rate());
  endtask

  // Reset values read back, then mecanum mixing around the point where scaling starts and at the extremes.
  task automatic test_reset_values();
    check_reg(REG_MIX_MODE);
    check_reg(REG_WHEEL_COUNT);
    check_reg(REG_OUTPUT_GAIN);
    send_cmd(16'sh0000, 16'sh0000, 16'sh0000);
    send_cmd(16'sh1000, 16'sh0000, 16'sh0000);
    send_cmd(16'sh1000, 16'sh0001, 16'sh0000);
    send_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_cmd(16'sh8000, 16'sh8000, 16'sh8000);
    send_cmd(16'sh7FFF, 16'sh8000, 16'sh0000);
    send_cmd(16'sh0000, 16'sh0000, 16'sh8000);
  endtask

  task automatic test_parallel_modes();
    set_mix(MODE_PARALLEL4, WHEELS_FOUR, 16'hFFFF);
    send_cmd(16'sh8000, 16'sh1234, 16'sh7FFF);
    send_cmd(16'sh0800, 16'sh0000, 16'sh0000);
    set_mix(MODE_PARALLEL2, WHEELS_TWO, 16'h0000);
    send_cmd(16'sh7FFF, 16'sh0000, 16'sh0000);
    set_mix(MODE_PARALLEL2, WHEELS_TWO, 16'h0180);
    send_cmd(16'shF001, 16'sh7FFF, 16'sh8000);
    send_cmd(16'sh0FFF, 16'sh0001, 16'shFFFF);
  endtask

  // Omni modes, undefined modes and wheel counts that do not suit the mode.
  task automatic test_error_cases();
    set_mix(MODE_OMNI_CROSS, WHEELS_FOUR, GAIN_RESET);
    send_cmd(16'sh1000, 16'sh0800, 16'shF800);
    set_mix(MODE_OMNI_PLUS, WHEELS_FOUR, GAIN_RESET);
    send_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    for (int mode = 5; mode < 8; mode++) begin
      set_mix(MODE_W'(mode), 3'd7, GAIN_RESET);
      send_cmd(16'sh0400, 16'sh0400, 16'sh0400);
    end
    set_mix(MODE_MECANUM, WHEELS_TWO, GAIN_RESET);
    send_cmd(16'sh0100, 16'sh0000, 16'sh0000);
    set_mix(MODE_PARALLEL4, 3'd0, GAIN_RESET);
    send_cmd(16'sh0100, 16'sh0000, 16'sh0000);
    set_mix(MODE_PARALLEL2, WHEELS_FOUR, GAIN_RESET);
    send_cmd(16'sh0100, 16'sh0000, 16'sh0000);
  endtask

  task automatic test_random_mix();
    set_mix(MODE_MECANUM, WHEELS_FOUR, GAIN_RESET);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(100);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_random(100);
    set_mix(MODE_MECANUM, WHEELS_FOUR, 16'h0000);
    run_random(40);
    set_mix(MODE_MECANUM, WHEELS_FOUR, 16'hFFFF);
    run_random(100);
    set_mix(MODE_MECANUM, WHEELS_FOUR, 16'h0001);
    run_random(40);
    set_mix(MODE_MECANUM, WHEELS_FOUR, GAIN_W'($urandom_range(0, 65535)));
    run_random(100);
    set_mix(MODE_PARALLEL4, WHEELS_FOUR, GAIN_W'($urandom_range(0, 65535)));
    run_random(120);
    set_mix(MODE_PARALLEL2, WHEELS_TWO, GAIN_W'($urandom_range(0, 65535)));
    tx_idle_on = 1'b0;
    run_random(120);
    tx_idle_on = 1'b1;
    set_mix(MODE_PARALLEL2, WHEELS_TWO, 16'hFFFF);
    run_random(40);
    repeat (4) begin
      set_mix(MODE_W'($urandom_range(0, 7)), COUNT_W'($urandom_range(0, 7)),
              GAIN_W'($urandom_range(0, 65535)));
      run_random(20);
    end
  endtask

  // Bursts at full rate into a stalling receiver, each followed by a full drain.
  task automatic test_drain_pause();
    set_mix(MODE_MECANUM, WHEELS_FOUR, GAIN_W'($urandom_range(0, 65535)));
    tx_idle_on = 1'b0;
    repeat (4) begin
      run_random($urandom_range(5, 30));
      wait_idle();
    end
    tx_idle_on = 1'b1;
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    forward_rate_i <= '0;
    side_rate_i    <= '0;
    turn_rate_i    <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_parallel_modes();
    test_error_cases();
    test_random_mix();
    test_drain_pause();
    wait_idle();
    repeat (NUM_STAGES + 4) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
